FILE: design/swc_pkg.sv
// Package: shared widths, constants and result payload type of the strided window canonicaliser.
package swc_pkg;

   localparam int WORD_W   = 64;
   localparam int STRIDE_W = 7;
   localparam int PHASE_W  = 6;
   localparam int COUNT_W  = 13;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   typedef struct packed {
      logic [WORD_W-1:0]   canonical_word;
      logic [STRIDE_W-1:0] stride;
      logic [PHASE_W-1:0]  phase;
      logic                full_res;
      logic                last;
   } rsp_payload_type;

endpackage

FILE: design/swc_if.sv
// Interfaces: request and response channels of the strided window canonicaliser.
interface swc_req_if;
   logic valid;
   logic ready;
   logic symbol_bit;
   logic restart;

   modport source (output valid, output symbol_bit, output restart, input ready);
   modport sink   (input valid, input symbol_bit, input restart, output ready);
endinterface

interface swc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] canonical_word;
   logic [6:0]  stride;
   logic [5:0]  phase;
   logic        full_res;
   logic        last;

   modport source (output valid, output canonical_word, output stride, output phase,
                   output full_res, output last, input ready);
   modport sink   (input valid, input canonical_word, input stride, input phase,
                   input full_res, input last, output ready);
endinterface

FILE: design/swc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module swc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 528,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/swc_canon.sv
// Window update and canonical form: shift in the bit, reverse, take the minimum, or zero while not full.
module swc_canon
   import swc_pkg::*;
(
   input  logic [WORD_W-1:0]   win_old,
   input  logic                bit_in,
   input  logic [COUNT_W-1:0]  count,
   input  logic [STRIDE_W-1:0] stride,
   input  logic [PHASE_W-1:0]  phase,
   input  logic                last_in,
   output logic [WORD_W-1:0]   win_new,
   output rsp_payload_type     payload
);

   logic [WORD_W-1:0] win_rev;
   logic              full;

   assign win_new = {win_old[WORD_W-2:0], bit_in};

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         win_rev[i] = win_new[WORD_W-1-i];
      end
   end

   // 64*b + a packs as {b, a} since a < 64
   assign full = (count >= {stride, phase});

   always_comb begin
      payload.canonical_word = '0;
      if (full) begin
         payload.canonical_word = (win_new < win_rev) ? win_new : win_rev;
      end
      payload.stride   = stride;
      payload.phase    = phase;
      payload.full_res = full;
      payload.last     = last_in;
   end

endmodule

FILE: design/strided_window_canonicalizer.sv
// Top level: sequencer, window RAM, phase ring and output register of the canonicaliser.
//
//   channel   dir   payload                                          handshake
//   req_chan  in    symbol_bit, restart                              valid/ready
//   rsp_chan  out   canonical_word, stride, phase, full_res, last    valid/ready
//   csr       in    csr_wr_data (stride flags)                       csr_wr_en
//
// An item occupies its transfer cycle and then one stride per cycle through the single read
// port of the window RAM, before req ready returns; a stride waits while the response
// register is held by a stalled sink.
// After reset a clearing pass writes zero to all STRIDES*(STRIDES+1)/2 windows
// (528 at the default), during which no request is taken.
// CSR writes are taken in every cycle.
module strided_window_canonicalizer
   import swc_pkg::*;
#(
   parameter int STRIDES = 32
) (
   input  logic               clock,
   input  logic               reset,
   swc_req_if.sink            req_chan,
   swc_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [WORD_W-1:0]  csr_wr_data
);

   localparam int NUM_WIN = STRIDES * (STRIDES + 1) / 2;
   localparam int ADDR_W  = (NUM_WIN > 1) ? $clog2(NUM_WIN) : 1;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [PHASE_W-1:0]  ring_ff [STRIDES];
   logic [PHASE_W-1:0]  ring_in [STRIDES];
   logic [WORD_W-1:0]   flags_ff, flags_in;
   logic                sym_ff, sym_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PHASE_W-1:0]  a_ff, a_in;
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     out_ff, out_in;

   logic                req_take;
   logic                out_free;
   logic                last_stride;
   logic [PHASE_W-1:0]  src_ring [STRIDES];
   logic [STRIDE_W-1:0] iss_b;
   logic [ADDR_W-1:0]   iss_base;
   logic [PHASE_W-1:0]  iss_a;
   logic [PHASE_W-1:0]  iss_a_next;
   logic [STRIDE_W-1:0] a_inc;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]   ram_rd_data;

   logic [PHASE_W-1:0]  flag_idx;
   logic [WORD_W-1:0]   win_new;
   rsp_payload_type     payload;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign last_stride    = (stride_ff == STRIDE_W'(STRIDES));
   assign flag_idx       = PHASE_W'(stride_ff - 7'd1);

   swc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WIN)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   swc_canon u_canon (
      .win_old (ram_rd_data),
      .bit_in  (sym_ff ^ flags_ff[flag_idx]),
      .count   (count_ff),
      .stride  (stride_ff),
      .phase   (a_ff),
      .last_in (last_stride),
      .win_new (win_new),
      .payload (payload)
   );

   // Next stride to read: its phase comes from the head of the ring
   always_comb begin
      for (int i = 0; i < STRIDES; i++) begin
         src_ring[i] = (state_ff == ST_IDLE && req_chan.restart) ? '0 : ring_ff[i];
      end
      if (state_ff == ST_IDLE) begin
         iss_b    = 7'd1;
         iss_base = '0;
      end else begin
         iss_b    = stride_ff + 7'd1;
         iss_base = base_ff + ADDR_W'(stride_ff);
      end
      iss_a      = ({1'b0, src_ring[0]} >= iss_b) ? '0 : src_ring[0];
      a_inc      = {1'b0, iss_a} + 7'd1;
      iss_a_next = (a_inc >= iss_b) ? '0 : PHASE_W'(a_inc);
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      count_in     = count_ff;
      ring_in      = ring_ff;
      flags_in     = csr_wr_en ? csr_wr_data : flags_ff;
      sym_in       = sym_ff;
      stride_in    = stride_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      a_in         = a_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = win_new;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = iss_base + ADDR_W'(iss_a);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(NUM_WIN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               sym_in    = req_chan.symbol_bit;
               count_in  = req_chan.restart ? '0 : count_ff;
               ram_rd_en = 1'b1;
               stride_in = iss_b;
               base_in   = iss_base;
               a_in      = iss_a;
               addr_in   = ram_rd_addr;
               for (int i = 0; i < STRIDES - 1; i++) begin
                  ring_in[i] = src_ring[i+1];
               end
               ring_in[STRIDES-1] = iss_a_next;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               ram_wr_en    = 1'b1;
               out_in       = payload;
               out_valid_in = 1'b1;
               if (last_stride) begin
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
                  state_in = ST_IDLE;
               end else begin
                  ram_rd_en = 1'b1;
                  stride_in = iss_b;
                  base_in   = iss_base;
                  a_in      = iss_a;
                  addr_in   = ram_rd_addr;
                  for (int i = 0; i < STRIDES - 1; i++) begin
                     ring_in[i] = src_ring[i+1];
                  end
                  ring_in[STRIDES-1] = iss_a_next;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         for (int i = 0; i < STRIDES; i++) begin
            ring_ff[i] <= '0;
         end
         flags_ff     <= '0;
         stride_ff    <= 7'd1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         count_ff     <= count_in;
         ring_ff      <= ring_in;
         flags_ff     <= flags_in;
         stride_ff    <= stride_in;
         out_valid_ff <= out_valid_in;
      end
      sym_ff  <= sym_in;
      base_ff <= base_in;
      addr_ff <= addr_in;
      a_ff    <= a_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.canonical_word = out_ff.canonical_word;
   assign rsp_chan.stride         = out_ff.stride;
   assign rsp_chan.phase          = out_ff.phase;
   assign rsp_chan.full_res       = out_ff.full_res;
   assign rsp_chan.last           = out_ff.last;

`ifndef SYNTHESIS
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.restart) |=> (count_ff == '0))
      else $error("count not cleared by restart");

   a_first_stride: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RUN && stride_ff == 7'd1 && addr_ff == '0))
      else $error("item did not start at stride one");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.stride >= 7'd1 && rsp_chan.stride <= STRIDE_W'(STRIDES)
                          && {1'b0, rsp_chan.phase} < rsp_chan.stride))
      else $error("response stride or phase out of range");

   a_last_tag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && out_free && last_stride) |=> (state_ff == ST_IDLE && rsp_chan.last))
      else $error("last stride did not close the item");
`endif

endmodule

FILE: tb/strided_window_canonicalizer_tb.sv
// Testbench: random and directed bit streams through the canonicaliser, checked against a window predictor.
module strided_window_canonicalizer_tb
   import swc_pkg::*;
();

   localparam int N_STRIDES  = 32;
   localparam int N_WINDOWS  = N_STRIDES * (N_STRIDES + 1) / 2;
   localparam int HOLD_TICKS = 300;
   localparam int TAIL_ITEMS = 210;

   class canon_scoreboard;
      logic [WORD_W-1:0]  flip_flags;
      logic [WORD_W-1:0]  windows [N_WINDOWS];
      logic [COUNT_W-1:0] bit_count;
      logic [PHASE_W-1:0] phases [N_STRIDES];
      rsp_payload_type    awaited [$];
      int errors;
      int bits_taken;
      int words_checked;
      int full_words;
      int restarts_seen;

      function new();
         flip_flags = '0;
         bit_count  = '0;
         foreach (windows[i]) windows[i] = '0;
         foreach (phases[i]) phases[i] = '0;
         errors        = 0;
         bits_taken    = 0;
         words_checked = 0;
         full_words    = 0;
         restarts_seen = 0;
      endfunction

      function void set_flags(input logic [WORD_W-1:0] v);
         flip_flags = v;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      function logic [WORD_W-1:0] mirror(input logic [WORD_W-1:0] x);
         logic [WORD_W-1:0] r;
         for (int i = 0; i < WORD_W; i++) r[i] = x[WORD_W-1-i];
         return r;
      endfunction

      // One accepted bit: one expected word per stride, in stride order.
      function void note_bit(input bit sym, input bit rst);
         int              a;
         int              idx;
         logic [WORD_W-1:0] w;
         logic [WORD_W-1:0] r;
         bit              full;
         rsp_payload_type e;
         if (rst) begin
            bit_count = '0;
            foreach (phases[i]) phases[i] = '0;
            restarts_seen++;
         end
         for (int b = 1; b <= N_STRIDES; b++) begin
            a = phases[b-1];
            if (a >= b) a = 0;
            idx = b * (b - 1) / 2 + a;
            w = {windows[idx][WORD_W-2:0], sym ^ flip_flags[b-1]};
            windows[idx] = w;
            r = mirror(w);
            full = int'(bit_count) >= 64 * b + a;
            e.canonical_word = full ? ((w < r) ? w : r) : '0;
            e.stride         = STRIDE_W'(b);
            e.phase          = PHASE_W'(a);
            e.full_res       = full;
            e.last           = (b == N_STRIDES);
            awaited = {awaited, e};
            phases[b-1] = (a + 1 >= b) ? '0 : PHASE_W'(a + 1);
         end
         if (bit_count < COUNT_MAX) bit_count++;
         bits_taken++;
      endfunction

      function void check_word(input rsp_payload_type got);
         rsp_payload_type e;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response transfer, got %h", $time, got);
            errors++;
            return;
         end
         e = awaited.pop_front();
         words_checked++;
         if (got.full_res) full_words++;
         if (got.canonical_word !== e.canonical_word) begin
            $display("%0t: canonical_word exp %h got %h", $time, e.canonical_word,
                     got.canonical_word);
            errors++;
         end
         if (got.stride !== e.stride) begin
            $display("%0t: stride exp %0d got %0d", $time, e.stride, got.stride);
            errors++;
         end
         if (got.phase !== e.phase) begin
            $display("%0t: phase exp %0d got %0d", $time, e.phase, got.phase);
            errors++;
         end
         if (got.full_res !== e.full_res) begin
            $display("%0t: full_res exp %b got %b", $time, e.full_res, got.full_res);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [WORD_W-1:0] csr_wr_data;
   bit                quiet;
   bit                hold_off;
   canon_scoreboard   sb;

   swc_req_if req_chan ();
   swc_rsp_if rsp_chan ();

   strided_window_canonicalizer #(
      .STRIDES (N_STRIDES)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #24_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_TICKS) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.canonical_word = rsp_chan.canonical_word;
         got.stride         = rsp_chan.stride;
         got.phase          = rsp_chan.phase;
         got.full_res       = rsp_chan.full_res;
         got.last           = rsp_chan.last;
         sb.check_word(got);
      end
   end

   task automatic send_bit(input bit sym, input bit rst);
      req_chan.valid      <= 1'b1;
      req_chan.symbol_bit <= sym;
      req_chan.restart    <= rst;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_bit(sym, rst);
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_flags(input logic [WORD_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_flags(v);
   endtask

   task automatic random_stream(input int n);
      for (int i = 0; i < n; i++) begin
         send_bit(1'($urandom_range(0, 1)), ($urandom_range(0, 63) == 0));
         sender_gap();
      end
   endtask

   initial begin
      sb       = new();
      quiet    = 1'b0;
      hold_off = 1'b0;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.symbol_bit <= 1'b0;
      req_chan.restart    <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all flips set, both bit values, restart at zero and mid-stream
      write_flags({WORD_W{1'b1}});
      send_bit(1'b1, 1'b1);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b0, 1'b1);
      send_bit(1'b1, 1'b1);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      drain();
      write_flags('0);
      for (int i = 0; i < 10; i++) send_bit(i[0], i == 7);
      drain();

      write_flags(64'hAAAA_5555_F0F0_0F0F);
      random_stream(120);
      drain();

      // long response stall while requests keep coming
      hold_off = 1'b1;
      for (int i = 0; i < 12; i++) send_bit(1'($urandom_range(0, 1)), 1'b0);
      drain();

      write_flags({$urandom, $urandom});
      random_stream(100);
      drain();

      // no idling from here: an unbroken stream from a restart fills the short-stride windows
      write_flags({$urandom, $urandom});
      quiet = 1'b1;
      send_bit(1'($urandom_range(0, 1)), 1'b1);
      for (int i = 1; i < TAIL_ITEMS; i++) send_bit(1'($urandom_range(0, 1)), 1'b0);
      drain();
      repeat (40) @(posedge clock);

      if (sb.outstanding() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, sb.outstanding());
         sb.errors++;
      end
      $display("Ran %0d request transfers (%0d with restart) and checked %0d responses,",
               sb.bits_taken, sb.restarts_seen, sb.words_checked);
      $display("%0d of them on full windows, through five flag settings and a long hold-off",
               sb.full_words);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
